@@ src/itr_pkg.sv @@
`default_nettype none
package itr_pkg;

  localparam logic [13:0] MAX_VALUE = 14'd3999;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic             oor;
    logic             zero;
    logic [3:0][3:0]  digits;
  } entry_t;

  typedef enum logic {
    FR_IDLE,
    FR_SPLIT
  } front_state_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_V = 8'h56;
  localparam logic [7:0] CH_X = 8'h58;
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_NONE = 8'h00;

  function automatic logic [13:0] place_val(input logic [1:0] p);
    logic [13:0] r;
    unique case (p)
      2'd0: r = 14'd1;
      2'd1: r = 14'd10;
      2'd2: r = 14'd100;
      default: r = 14'd1000;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sym_one(input logic [1:0] p);
    logic [7:0] r;
    unique case (p)
      2'd0: r = CH_I;
      2'd1: r = CH_X;
      2'd2: r = CH_C;
      default: r = CH_M;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sym_five(input logic [1:0] p);
    logic [7:0] r;
    unique case (p)
      2'd0: r = CH_V;
      2'd1: r = CH_L;
      2'd2: r = CH_D;
      default: r = CH_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sym_ten(input logic [1:0] p);
    logic [7:0] r;
    unique case (p)
      2'd0: r = CH_X;
      2'd1: r = CH_C;
      2'd2: r = CH_M;
      default: r = CH_NONE;
    endcase
    return r;
  endfunction

  // Number of symbols a decimal digit expands to.
  function automatic logic [2:0] digit_len(input digit_t d);
    logic [2:0] r;
    unique case (d)
      4'd0: r = 3'd0;
      4'd1, 4'd5: r = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9: r = 3'd2;
      4'd3, 4'd7: r = 3'd3;
      4'd8: r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] roman_sym(input digit_t d, input logic [1:0] p,
                                           input logic [1:0] j);
    logic [7:0] r;
    if (d == 4'd9) begin
      r = (j == 2'd0) ? sym_one(p) : sym_ten(p);
    end else if (d == 4'd4) begin
      r = (j == 2'd0) ? sym_one(p) : sym_five(p);
    end else if (d >= 4'd5 && j == 2'd0) begin
      r = sym_five(p);
    end else begin
      r = sym_one(p);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/itr_front.sv @@
`default_nettype none
module itr_front
  import itr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [13:0] value,
  input  wire logic        q_full,
  output logic             busy,
  output logic             push,
  output entry_t           push_entry
);

  front_state_t    state, state_next;
  logic [11:0]     rem;
  logic [1:0]      place;
  logic [3:0][3:0] digits;

  digit_t          dig;
  logic [13:0]     sub;
  logic [3:0][3:0] split_digits;
  logic            accept;
  logic            special;

  assign accept  = start && !busy;
  assign special = (value > MAX_VALUE) || (value == 14'd0);

  always_comb begin
    dig = '0;
    sub = '0;
    for (int k = 1; k <= 9; k++) begin
      if ({2'b00, rem} >= 14'(k) * place_val(place)) begin
        dig = 4'(k);
        sub = 14'(k) * place_val(place);
      end
    end
  end

  always_comb begin
    split_digits        = digits;
    split_digits[place] = dig;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: begin
        if (accept && !special) state_next = FR_SPLIT;
      end
      FR_SPLIT: begin
        if (place == 2'd0 && !q_full) state_next = FR_IDLE;
      end
      default: state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state != FR_IDLE) || q_full;
    push       = 1'b0;
    push_entry = '0;
    unique case (state)
      FR_IDLE: begin
        push            = start && !q_full && special;
        push_entry.oor  = value > MAX_VALUE;
        push_entry.zero = value == 14'd0;
      end
      FR_SPLIT: begin
        push              = (place == 2'd0) && !q_full;
        push_entry.digits = split_digits;
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == FR_IDLE) begin
      if (accept) begin
        rem    <= value[11:0];
        place  <= 2'd3;
        digits <= '0;
      end
    end else if (place != 2'd0) begin
      digits[place] <= dig;
      rem           <= rem - sub[11:0];
      place         <= place - 2'd1;
    end
  end

endmodule
`default_nettype wire

@@ src/itr_queue.sv @@
`default_nettype none
module itr_queue
  import itr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output logic        full,
  output logic        empty,
  output entry_t      head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full  = count == CW'(DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ src/itr_back.sv @@
`default_nettype none
module itr_back
  import itr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_empty,
  input  wire entry_t head,
  output logic        pop,
  output logic        strobe,
  output logic [7:0]  symbol,
  output logic        last,
  output logic        out_of_range
);

  back_state_t state, state_next;
  entry_t      cur;
  logic [1:0]  place;
  logic [1:0]  pos;

  digit_t      d;
  logic [2:0]  len;
  logic        emit;
  logic        lower_zero;
  logic        fin;

  assign d   = cur.digits[place];
  assign len = digit_len(d);

  always_comb begin
    lower_zero = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (2'(i) < place && cur.digits[i] != 4'd0) lower_zero = 1'b0;
    end
  end

  assign emit = {1'b0, pos} < len;
  assign fin  = (cur.oor || cur.zero) ||
                (emit && ({1'b0, pos} == len - 3'd1) && lower_zero);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) state_next = BK_RUN;
      end
      BK_RUN: begin
        if (fin) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    unique case (state)
      BK_IDLE: pop = !q_empty;
      BK_RUN:  pop = 1'b0;
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= BK_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == BK_RUN) && (cur.oor || cur.zero || emit);
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE) begin
      if (!q_empty) begin
        cur   <= head;
        place <= 2'd3;
        pos   <= 2'd0;
      end
    end else begin
      if (!emit || ({1'b0, pos} == len - 3'd1)) begin
        place <= place - 2'd1;
        pos   <= 2'd0;
      end else begin
        pos <= pos + 2'd1;
      end
    end
    if (cur.oor || cur.zero) begin
      symbol <= CH_NONE;
    end else begin
      symbol <= roman_sym(d, place, pos);
    end
    last         <= fin;
    out_of_range <= cur.oor;
  end

endmodule
`default_nettype wire

@@ src/integer_to_roman_numeral.sv @@
`default_nettype none
// Channel   Ports                              Transfer
// input     start, value[13:0] / busy          edge with start high and busy low
// result    strobe, symbol[7:0], last,         every edge that ends a cycle with
//           out_of_range                       strobe high
//
// The front part splits a number into decimal digits, one digit per cycle, and pushes the entry
// once the queue has room; zero and values above 3999 go to the queue at their transfer.
// The back part pops an entry only when idle, then emits its symbols one per cycle from the
// highest digit down, passing over zero digits without a strobe, and takes no new entry until
// it has sent the last symbol of the current one.
// Busy is high while the front splits or the two-entry queue is full; reset clears both
// state machines and the queue, and the receiver cannot stall results.
module integer_to_roman_numeral
  import itr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [13:0] value,
  output logic             busy,
  output logic             strobe,
  output logic [7:0]       symbol,
  output logic             last,
  output logic             out_of_range
);

  logic   q_full;
  logic   q_empty;
  logic   push;
  logic   pop;
  entry_t push_entry;
  entry_t head;

  itr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .value      (value),
    .q_full     (q_full),
    .busy       (busy),
    .push       (push),
    .push_entry (push_entry)
  );

  itr_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (head)
  );

  itr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .strobe       (strobe),
    .symbol       (symbol),
    .last         (last),
    .out_of_range (out_of_range)
  );

`ifndef SYNTHESIS
  a_oor_single : assert property (@(posedge clk) disable iff (rst)
    strobe && out_of_range |-> last && symbol == CH_NONE)
    else $error("out of range result not a single empty symbol");

  a_empty_last : assert property (@(posedge clk) disable iff (rst)
    strobe && symbol == CH_NONE |-> last)
    else $error("empty symbol not marked last");

  a_no_push_full : assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("queue written while full");

  a_no_pop_empty : assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none
module tb;
  import itr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
    logic       oor;
  } numeral_symbol_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic [13:0] value;
  logic        busy;
  logic        strobe;
  logic [7:0]  symbol;
  logic        last;
  logic        out_of_range;

  numeral_symbol_t pending_symbols[$];
  int mismatch_count;
  int idle_cycles;
  int sender_idle_pct;

  logic [7:0] one_sym[4];
  logic [7:0] five_sym[4];
  logic [7:0] ten_sym[4];
  int         place_scale[4];

  integer_to_roman_numeral u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .value        (value),
    .busy         (busy),
    .strobe       (strobe),
    .symbol       (symbol),
    .last         (last),
    .out_of_range (out_of_range)
  );

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // Expands one accepted number into the symbols the block should emit.
  task automatic expand_numeral(input logic [13:0] num);
    logic [7:0]      syms[16];
    numeral_symbol_t item;
    int              k;
    int              d;
    int              p;
    int              i;
    k = 0;
    if (num > 14'd3999) begin
      item.symbol = CH_NONE;
      item.last = 1'b1;
      item.oor = 1'b1;
      pending_symbols.push_back(item);
    end else if (num == 14'd0) begin
      item.symbol = CH_NONE;
      item.last = 1'b1;
      item.oor = 1'b0;
      pending_symbols.push_back(item);
    end else begin
      for (p = 3; p >= 0; p--) begin
        d = (int'(num) / place_scale[p]) % 10;
        if (d == 9) begin
          syms[k] = one_sym[p];
          syms[k + 1] = ten_sym[p];
          k = k + 2;
        end else if (d == 4) begin
          syms[k] = one_sym[p];
          syms[k + 1] = five_sym[p];
          k = k + 2;
        end else begin
          if (d >= 5) begin
            syms[k] = five_sym[p];
            k = k + 1;
            d = d - 5;
          end
          for (i = 0; i < d; i++) begin
            syms[k] = one_sym[p];
            k = k + 1;
          end
        end
      end
      for (i = 0; i < k; i++) begin
        item.symbol = syms[i];
        item.last = (i == k - 1);
        item.oor = 1'b0;
        pending_symbols.push_back(item);
      end
    end
  endtask

  // Offers one number and returns in the time step of its transfer, or after the idle gap that follows it.
  // Start stays high unless a gap follows, so the next call can continue back to back.
  task automatic send_number(input logic [13:0] num);
    int gap;
    start <= 1'b1;
    value <= num;
    do @(posedge clk); while (busy);
    expand_numeral(num);
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
  endtask

  function automatic logic [13:0] random_number();
    int r;
    r = $urandom_range(99);
    if (r < 85) return 14'($urandom_range(3999, 1));
    else if (r < 90) return 14'd0;
    else if (r < 95) return 14'($urandom_range(9999, 4000));
    else return 14'($urandom_range(16383, 10000));
  endfunction

  task automatic test_directed_values();
    logic [13:0] nums[25];
    nums = '{14'd0, 14'd1, 14'd4, 14'd5, 14'd9, 14'd10, 14'd14, 14'd40, 14'd49,
             14'd90, 14'd99, 14'd400, 14'd444, 14'd900, 14'd999, 14'd1000,
             14'd1994, 14'd3444, 14'd3888, 14'd3999, 14'd4000, 14'd9999,
             14'd10000, 14'd16383, 14'd2768};
    sender_idle_pct = 0;
    foreach (nums[i]) send_number(nums[i]);
    wait_for_drain();
  endtask

  task automatic test_back_to_back(input int count);
    sender_idle_pct = 0;
    repeat (count) send_number(random_number());
    wait_for_drain();
  endtask

  task automatic test_sparse_sender(input int count);
    sender_idle_pct = 84;
    repeat (count) send_number(random_number());
    wait_for_drain();
  endtask

  task automatic test_light_idle(input int count);
    sender_idle_pct = 28;
    repeat (count) send_number(random_number());
    wait_for_drain();
  endtask

  // The sender holds off until every pending symbol is out, then resumes.
  task automatic test_drain_pause();
    sender_idle_pct = 0;
    repeat (6) send_number(random_number());
    wait_for_drain();
    repeat (6) send_number(random_number());
    wait_for_drain();
  endtask

  always @(posedge clk) begin
    numeral_symbol_t exp_sym;
    if (!rst && strobe === 1'b1) begin
      if (pending_symbols.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected symbol %h last %b oor %b", $time, symbol, last,
                 out_of_range);
      end else begin
        exp_sym = pending_symbols.pop_front();
        if (symbol !== exp_sym.symbol) begin
          mismatch_count++;
          $display("%0t: symbol expected %h actual %h", $time, exp_sym.symbol, symbol);
        end
        if (last !== exp_sym.last) begin
          mismatch_count++;
          $display("%0t: last expected %b actual %b", $time, exp_sym.last, last);
        end
        if (out_of_range !== exp_sym.oor) begin
          mismatch_count++;
          $display("%0t: out_of_range expected %b actual %b", $time, exp_sym.oor,
                   out_of_range);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    one_sym = '{CH_I, CH_X, CH_C, CH_M};
    five_sym = '{CH_V, CH_L, CH_D, CH_NONE};
    ten_sym = '{CH_X, CH_C, CH_M, CH_NONE};
    place_scale = '{1, 10, 100, 1000};
    mismatch_count = 0;
    sender_idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    value = 14'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_values();
    test_back_to_back(125);
    test_sparse_sender(125);
    test_light_idle(125);
    test_drain_pause();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
src/itr_pkg.sv
src/itr_front.sv
src/itr_queue.sv
src/itr_back.sv
src/integer_to_roman_numeral.sv
verif/tb.sv
